@@ rtl/core/hmg_pkg.sv @@
// Shared types and constants for the hemisphere mesh generator.
// Holds the controller states, datapath operations, status and command
// structs, and the quarter-wave sine ROM contents built at elaboration.
package hmg_pkg;

    // Result kinds
    localparam logic [1:0] KIND_VERTEX   = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [1:0] KIND_DONE     = 2'd2;

    // Register index decoded from paddr[2]
    localparam logic REG_DIVISIONS = 1'b0;

    localparam logic [6:0]  DIVISIONS_RESET = 7'd8;
    localparam logic [14:0] ONE_Q14         = 15'd16384;
    localparam logic [10:0] THETA_FULL      = 11'd1024;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Taylor term denominators (2m)*(2m+1) for m = 1..7
    localparam longint unsigned TAYLOR_DEN [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156, 64'd210};

    typedef logic [14:0] sine_rom_t [1024];

    // Build sin(k*pi/2048) in Q1.14 from an 8-term Taylor series in Q30
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          sum;
        for (int k = 0; k < 1024; k++)
        begin
            x   = (longint'(k) * HALF_PI_Q30) >> 10;
            x2  = (x * x) >> 30;
            t   = x;
            sum = longint'(x);
            for (int m = 1; m <= 7; m++)
            begin
                t = ((t * x2) >> 30) / TAYLOR_DEN[m-1];
                if ((m & 1) == 1)
                    sum = sum - longint'(t);
                else
                    sum = sum + longint'(t);
            end
            if (sum < 0)
                sum = 0;
            rom[k] = 15'((longint'(sum) + 64'd32768) >> 16);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    typedef enum logic [4:0] {
        S_IDLE,
        S_TOP,
        S_FIN,
        S_TH_GO,
        S_TH_WAIT,
        S_PHI_GO,
        S_PHI_WAIT,
        S_ROM_A,
        S_ROM_B,
        S_ROM_C,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_MUL_D,
        S_GAPS,
        S_ROW_EMIT,
        S_V_EMIT,
        S_TRI1,
        S_TRI2
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_START_INIT,
        OP_SET_FIN,
        OP_ROW_ADV,
        OP_COL_ADV,
        OP_TH_DIV,
        OP_TH_CAP,
        OP_PHI_DIV,
        OP_PHI_CAP,
        OP_ROM_A,
        OP_ROM_B,
        OP_ROM_C,
        OP_MUL_A,
        OP_MUL_B,
        OP_MUL_C,
        OP_MUL_D,
        OP_GAPS,
        OP_EMIT_TOP,
        OP_EMIT_FIN,
        OP_EMIT_ROWV,
        OP_EMIT_VERT,
        OP_EMIT_TRI1,
        OP_EMIT_TRI2
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic run;
        logic row_end;
        logic rows_done;
        logic div_busy;
        logic out_free;
        logic row_path;
        logic tri_pair;
    } status_t;

endpackage

@@ rtl/core/hmg_in_if.sv @@
// Input channel of the hemisphere mesh generator: valid/ready and start_req.
// No dependencies.
interface hmg_in_if;
    logic valid;
    logic ready;
    logic start_req;

    modport source (output valid, output start_req, input ready);
    modport sink (input valid, input start_req, output ready);
endinterface

@@ rtl/core/hmg_out_if.sv @@
// Result channel of the hemisphere mesh generator: valid/ready and payload.
// No dependencies.
interface hmg_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [12:0]        tex_u;
    logic [10:0]        tex_v;
    logic [15:0]        corner_a;
    logic [15:0]        corner_b;
    logic [15:0]        corner_c;
    logic               last;

    modport source (output valid, output kind, output pos_x, output pos_y, output pos_z,
                    output tex_u, output tex_v, output corner_a, output corner_b,
                    output corner_c, output last, input ready);
    modport sink (input valid, input kind, input pos_x, input pos_y, input pos_z,
                  input tex_u, input tex_v, input corner_a, input corner_b,
                  input corner_c, input last, output ready);
endinterface

@@ rtl/core/hmg_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; used by the datapath for theta and phi.
module hmg_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Shift in the next numerator bit and try the subtraction
    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Payload: load operands, then advance one bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (cnt_reg != '0)
        begin
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
            rem_reg  <= fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

endmodule

@@ rtl/core/hmg_datapath.sv @@
// Datapath of the hemisphere mesh generator: mesh state, divider, sine ROM,
// shared multiplier and the result register. Depends on hmg_pkg, hmg_div,
// hmg_out_if.
module hmg_datapath #(
    parameter int MAX_DIVISIONS = 127,
    parameter int ANGLE_BITS    = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [6:0]      divisions,
    input  hmg_pkg::cmd_t   cmd,
    output hmg_pkg::status_t stat,
    hmg_out_if.source       out_ch
);

    localparam int NUM_W = 9 + ANGLE_BITS;
    localparam int PHI_W = ANGLE_BITS + 1;
    localparam int R_W   = ANGLE_BITS - 2;
    localparam logic [R_W:0]       QUARTER   = (R_W + 1)'(1) << R_W;
    localparam logic [PHI_W-1:0]   HALF_TURN = PHI_W'(1) << (ANGLE_BITS - 1);
    localparam logic [6:0]         MAX_DIV   = 7'(MAX_DIVISIONS);
    localparam logic [10:0]        THETA_FULL_W = hmg_pkg::THETA_FULL;

    // Mesh state
    logic [6:0]  row_reg;
    logic [8:0]  col_reg;
    logic [8:0]  back_reg;
    logic [8:0]  gaps_reg;
    logic [8:0]  prev_reg;
    logic [15:0] base_reg;
    logic [15:0] vcount_reg;
    logic [14:0] sin_reg;
    logic [14:0] cos_reg;
    logic        run_reg;
    logic        row_path_reg;

    // Working registers
    logic [10:0]        th_reg;
    logic [PHI_W-1:0]   phi_reg;
    logic [14:0]        sa_reg;
    logic [14:0]        sb_reg;
    logic [14:0]        rom_q;
    logic [29:0]        prod_reg;
    logic [18:0]        tl_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;

    // Result register
    logic               ovalid_reg;
    logic [1:0]         okind_reg;
    logic signed [15:0] ox_reg;
    logic signed [15:0] oy_reg;
    logic signed [15:0] oz_reg;
    logic [12:0]        ou_reg;
    logic [10:0]        ov_reg;
    logic [15:0]        oa_reg;
    logic [15:0]        ob_reg;
    logic [15:0]        oc_reg;
    logic               olast_reg;

    // Next result payload
    logic [1:0]         okind_next;
    logic signed [15:0] ox_next;
    logic signed [15:0] oy_next;
    logic signed [15:0] oz_next;
    logic [12:0]        ou_next;
    logic [10:0]        ov_next;
    logic [15:0]        oa_next;
    logic [15:0]        ob_next;
    logic [15:0]        oc_next;
    logic               olast_next;

    logic [6:0]       n_eff;
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [8:0]       div_den;
    logic             div_busy;
    logic [NUM_W-1:0] div_quot;
    logic [1:0]       quad;
    logic [R_W-1:0]   r_val;
    logic [R_W:0]     qmr;
    logic [9:0]       idx_r;
    logic [9:0]       idx_q;
    logic [9:0]       rom_addr;
    logic [14:0]      mag_x;
    logic [14:0]      mag_y;
    logic             neg_x;
    logic             neg_y;
    logic [14:0]      mul_a;
    logic [14:0]      mul_b;
    logic [9:0]       two_k_m1;
    logic [24:0]      gaps_sum;
    logic [15:0]      pb;
    logic             tri_pair;
    logic             out_free;
    logic             emit;

    function automatic logic signed [15:0] scale_q14(logic [29:0] p, logic neg);
        logic [15:0] mag;
        mag = p[29:14];
        return neg ? signed'(16'd0 - mag) : signed'(mag);
    endfunction

    // Effective row count and divider operands
    assign n_eff     = (divisions > MAX_DIV) ? MAX_DIV : divisions;
    assign div_start = (cmd.op == hmg_pkg::OP_TH_DIV) || (cmd.op == hmg_pkg::OP_PHI_DIV);
    assign div_num   = (cmd.op == hmg_pkg::OP_TH_DIV) ? NUM_W'({row_reg, 10'b0})
                                                      : {col_reg, {ANGLE_BITS{1'b0}}};
    assign div_den   = (cmd.op == hmg_pkg::OP_TH_DIV) ? {2'b00, n_eff} : gaps_reg;

    hmg_div #(
        .NUM_W (NUM_W),
        .DEN_W (9)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Quadrant split of phi and table indices
    assign quad  = phi_reg[ANGLE_BITS-1 -: 2];
    assign r_val = phi_reg[R_W-1:0];
    assign qmr   = QUARTER - {1'b0, r_val};
    assign idx_r = 10'({r_val, 10'b0} >> R_W);
    assign idx_q = 10'({qmr, 10'b0} >> R_W);

    always_comb
    begin
        if (cmd.op == hmg_pkg::OP_ROM_A)
            rom_addr = row_path_reg ? th_reg[9:0] : idx_r;
        else
            rom_addr = row_path_reg ? 10'(THETA_FULL_W - th_reg) : idx_q;
    end

    always_ff @(posedge clk)
    begin
        rom_q <= hmg_pkg::SINE_ROM[rom_addr];
    end

    // Signs and magnitudes of cos(phi) and sin(phi)
    assign mag_x = quad[0] ? sa_reg : sb_reg;
    assign mag_y = quad[0] ? sb_reg : sa_reg;
    assign neg_x = (quad == 2'd1) || (quad == 2'd2);
    assign neg_y = quad[1];

    assign two_k_m1 = {back_reg, 1'b0} - 10'd1;

    // Shared multiplier operand selection
    always_comb
    begin
        case (cmd.op)
            hmg_pkg::OP_MUL_A:
            begin
                mul_a = row_path_reg ? 15'({n_eff, 2'b00}) : sin_reg;
                mul_b = row_path_reg ? sin_reg : mag_x;
            end
            hmg_pkg::OP_MUL_B:
            begin
                mul_a = sin_reg;
                mul_b = mag_y;
            end
            hmg_pkg::OP_MUL_C:
            begin
                mul_a = 15'(two_k_m1);
                mul_b = 15'(gaps_reg);
            end
            default:
            begin
                mul_a = 15'({col_reg, 1'b1});
                mul_b = 15'(prev_reg);
            end
        endcase
    end

    assign gaps_sum = prod_reg[24:0] + 25'd8192;
    assign pb       = base_reg - 16'(prev_reg) - 16'd1;
    assign tri_pair = (back_reg != 9'd0) && ({11'b0, tl_reg} <= prod_reg);
    assign out_free = !ovalid_reg || out_ch.ready;
    assign emit     = (cmd.op == hmg_pkg::OP_EMIT_TOP) || (cmd.op == hmg_pkg::OP_EMIT_FIN) ||
                      (cmd.op == hmg_pkg::OP_EMIT_ROWV) || (cmd.op == hmg_pkg::OP_EMIT_VERT) ||
                      (cmd.op == hmg_pkg::OP_EMIT_TRI1) || (cmd.op == hmg_pkg::OP_EMIT_TRI2);

    // Mesh state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            back_reg     <= 9'd1;
            gaps_reg     <= '0;
            prev_reg     <= '0;
            base_reg     <= '0;
            vcount_reg   <= '0;
            sin_reg      <= '0;
            cos_reg      <= '0;
            run_reg      <= 1'b0;
            row_path_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op) inside
                hmg_pkg::OP_START_INIT:
                begin
                    row_reg    <= '0;
                    col_reg    <= '0;
                    back_reg   <= 9'd1;
                    gaps_reg   <= '0;
                    prev_reg   <= '0;
                    base_reg   <= '0;
                    vcount_reg <= 16'd1;
                    sin_reg    <= '0;
                    cos_reg    <= hmg_pkg::ONE_Q14;
                    run_reg    <= 1'b1;
                end
                hmg_pkg::OP_SET_FIN:
                begin
                    run_reg <= 1'b0;
                end
                hmg_pkg::OP_ROW_ADV:
                begin
                    row_reg      <= row_reg + 7'd1;
                    row_path_reg <= 1'b1;
                end
                hmg_pkg::OP_COL_ADV:
                begin
                    col_reg      <= col_reg + 9'd1;
                    row_path_reg <= 1'b0;
                end
                hmg_pkg::OP_ROM_B:
                begin
                    if (row_path_reg)
                        sin_reg <= th_reg[10] ? hmg_pkg::ONE_Q14 : rom_q;
                end
                hmg_pkg::OP_ROM_C:
                begin
                    if (row_path_reg)
                        cos_reg <= (th_reg == '0) ? hmg_pkg::ONE_Q14 : rom_q;
                end
                hmg_pkg::OP_GAPS:
                begin
                    gaps_reg <= gaps_sum[22:14];
                    prev_reg <= gaps_reg;
                    base_reg <= vcount_reg;
                    col_reg  <= '0;
                    back_reg <= 9'd1;
                end
                hmg_pkg::OP_EMIT_ROWV, hmg_pkg::OP_EMIT_VERT:
                begin
                    vcount_reg <= vcount_reg + 16'd1;
                end
                hmg_pkg::OP_EMIT_TRI2:
                begin
                    back_reg <= back_reg + 9'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            hmg_pkg::OP_TH_CAP:
            begin
                if ((n_eff == '0) || (div_quot > NUM_W'(THETA_FULL_W)))
                    th_reg <= THETA_FULL_W;
                else
                    th_reg <= div_quot[10:0];
            end
            hmg_pkg::OP_PHI_CAP:
            begin
                phi_reg <= div_quot[PHI_W-1:0];
            end
            hmg_pkg::OP_ROM_B:
            begin
                sa_reg <= rom_q;
            end
            hmg_pkg::OP_ROM_C:
            begin
                sb_reg <= (r_val == '0) ? hmg_pkg::ONE_Q14 : rom_q;
            end
            hmg_pkg::OP_MUL_A:
            begin
                prod_reg <= mul_a * mul_b;
            end
            hmg_pkg::OP_MUL_B:
            begin
                x_reg    <= scale_q14(prod_reg, neg_x);
                prod_reg <= mul_a * mul_b;
            end
            hmg_pkg::OP_MUL_C:
            begin
                y_reg    <= scale_q14(prod_reg, neg_y);
                prod_reg <= mul_a * mul_b;
            end
            hmg_pkg::OP_MUL_D:
            begin
                tl_reg   <= prod_reg[18:0];
                prod_reg <= mul_a * mul_b;
            end
            default:
            begin
            end
        endcase
    end

    // Result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (emit)
            ovalid_reg <= 1'b1;
        else if (out_ch.ready)
            ovalid_reg <= 1'b0;
    end

    // Build the payload of the transaction being emitted
    always_comb
    begin
        okind_next = hmg_pkg::KIND_VERTEX;
        ox_next    = '0;
        oy_next    = '0;
        oz_next    = '0;
        ou_next    = '0;
        ov_next    = '0;
        oa_next    = '0;
        ob_next    = '0;
        oc_next    = '0;
        olast_next = 1'b1;
        case (cmd.op)
            hmg_pkg::OP_EMIT_TOP:
            begin
                oz_next = signed'({1'b0, hmg_pkg::ONE_Q14});
                ou_next = 13'(HALF_TURN);
            end
            hmg_pkg::OP_EMIT_FIN:
            begin
                okind_next = hmg_pkg::KIND_DONE;
            end
            hmg_pkg::OP_EMIT_ROWV:
            begin
                ox_next = signed'({1'b0, sin_reg});
                oz_next = signed'({1'b0, cos_reg});
                ov_next = th_reg;
            end
            hmg_pkg::OP_EMIT_VERT:
            begin
                ox_next    = x_reg;
                oy_next    = y_reg;
                oz_next    = signed'({1'b0, cos_reg});
                ou_next    = 13'(phi_reg);
                ov_next    = th_reg;
                olast_next = 1'b0;
            end
            hmg_pkg::OP_EMIT_TRI1:
            begin
                okind_next = hmg_pkg::KIND_TRIANGLE;
                oa_next    = base_reg + 16'(col_reg) - 16'd1;
                ob_next    = base_reg + 16'(col_reg);
                oc_next    = pb + 16'(back_reg) - 16'd1;
                olast_next = !tri_pair;
            end
            hmg_pkg::OP_EMIT_TRI2:
            begin
                okind_next = hmg_pkg::KIND_TRIANGLE;
                oa_next    = pb + 16'(back_reg) - 16'd1;
                ob_next    = base_reg + 16'(col_reg);
                oc_next    = pb + 16'(back_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            okind_reg <= okind_next;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            oz_reg    <= oz_next;
            ou_reg    <= ou_next;
            ov_reg    <= ov_next;
            oa_reg    <= oa_next;
            ob_reg    <= ob_next;
            oc_reg    <= oc_next;
            olast_reg <= olast_next;
        end
    end

    assign out_ch.valid    = ovalid_reg;
    assign out_ch.kind     = okind_reg;
    assign out_ch.pos_x    = ox_reg;
    assign out_ch.pos_y    = oy_reg;
    assign out_ch.pos_z    = oz_reg;
    assign out_ch.tex_u    = ou_reg;
    assign out_ch.tex_v    = ov_reg;
    assign out_ch.corner_a = oa_reg;
    assign out_ch.corner_b = ob_reg;
    assign out_ch.corner_c = oc_reg;
    assign out_ch.last     = olast_reg;

    // Status to the controller
    always_comb
    begin
        stat.run       = run_reg;
        stat.row_end   = (col_reg >= gaps_reg);
        stat.rows_done = (row_reg >= n_eff);
        stat.div_busy  = div_busy;
        stat.out_free  = out_free;
        stat.row_path  = row_path_reg;
        stat.tri_pair  = tri_pair;
    end

endmodule

@@ rtl/core/hmg_ctrl.sv @@
// Controller of the hemisphere mesh generator: accepts ticks and sequences
// the datapath operations. Depends on hmg_pkg and hmg_in_if.
module hmg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    hmg_in_if.sink           in_ch,
    input  hmg_pkg::status_t stat,
    output hmg_pkg::cmd_t    cmd
);

    hmg_pkg::ctrl_state_t state_reg;
    hmg_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hmg_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ch.ready = (state_reg == hmg_pkg::S_IDLE);

    // Next state and operation
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = hmg_pkg::OP_NOP;
        unique case (state_reg)
            hmg_pkg::S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.start_req)
                    begin
                        cmd.op     = hmg_pkg::OP_START_INIT;
                        state_next = hmg_pkg::S_TOP;
                    end
                    else if (!stat.run)
                    begin
                        state_next = hmg_pkg::S_FIN;
                    end
                    else if (stat.row_end)
                    begin
                        if (stat.rows_done)
                        begin
                            cmd.op     = hmg_pkg::OP_SET_FIN;
                            state_next = hmg_pkg::S_FIN;
                        end
                        else
                        begin
                            cmd.op     = hmg_pkg::OP_ROW_ADV;
                            state_next = hmg_pkg::S_TH_GO;
                        end
                    end
                    else
                    begin
                        cmd.op     = hmg_pkg::OP_COL_ADV;
                        state_next = hmg_pkg::S_TH_GO;
                    end
                end
            end
            hmg_pkg::S_TOP:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = hmg_pkg::OP_EMIT_TOP;
                    state_next = hmg_pkg::S_IDLE;
                end
            end
            hmg_pkg::S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = hmg_pkg::OP_EMIT_FIN;
                    state_next = hmg_pkg::S_IDLE;
                end
            end
            hmg_pkg::S_TH_GO:
            begin
                cmd.op     = hmg_pkg::OP_TH_DIV;
                state_next = hmg_pkg::S_TH_WAIT;
            end
            hmg_pkg::S_TH_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op     = hmg_pkg::OP_TH_CAP;
                    state_next = stat.row_path ? hmg_pkg::S_ROM_A : hmg_pkg::S_PHI_GO;
                end
            end
            hmg_pkg::S_PHI_GO:
            begin
                cmd.op     = hmg_pkg::OP_PHI_DIV;
                state_next = hmg_pkg::S_PHI_WAIT;
            end
            hmg_pkg::S_PHI_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op     = hmg_pkg::OP_PHI_CAP;
                    state_next = hmg_pkg::S_ROM_A;
                end
            end
            hmg_pkg::S_ROM_A:
            begin
                cmd.op     = hmg_pkg::OP_ROM_A;
                state_next = hmg_pkg::S_ROM_B;
            end
            hmg_pkg::S_ROM_B:
            begin
                cmd.op     = hmg_pkg::OP_ROM_B;
                state_next = hmg_pkg::S_ROM_C;
            end
            hmg_pkg::S_ROM_C:
            begin
                cmd.op     = hmg_pkg::OP_ROM_C;
                state_next = hmg_pkg::S_MUL_A;
            end
            hmg_pkg::S_MUL_A:
            begin
                cmd.op     = hmg_pkg::OP_MUL_A;
                state_next = stat.row_path ? hmg_pkg::S_GAPS : hmg_pkg::S_MUL_B;
            end
            hmg_pkg::S_MUL_B:
            begin
                cmd.op     = hmg_pkg::OP_MUL_B;
                state_next = hmg_pkg::S_MUL_C;
            end
            hmg_pkg::S_MUL_C:
            begin
                cmd.op     = hmg_pkg::OP_MUL_C;
                state_next = hmg_pkg::S_MUL_D;
            end
            hmg_pkg::S_MUL_D:
            begin
                cmd.op     = hmg_pkg::OP_MUL_D;
                state_next = hmg_pkg::S_V_EMIT;
            end
            hmg_pkg::S_GAPS:
            begin
                cmd.op     = hmg_pkg::OP_GAPS;
                state_next = hmg_pkg::S_ROW_EMIT;
            end
            hmg_pkg::S_ROW_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = hmg_pkg::OP_EMIT_ROWV;
                    state_next = hmg_pkg::S_IDLE;
                end
            end
            hmg_pkg::S_V_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = hmg_pkg::OP_EMIT_VERT;
                    state_next = hmg_pkg::S_TRI1;
                end
            end
            hmg_pkg::S_TRI1:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = hmg_pkg::OP_EMIT_TRI1;
                    state_next = stat.tri_pair ? hmg_pkg::S_TRI2 : hmg_pkg::S_IDLE;
                end
            end
            hmg_pkg::S_TRI2:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = hmg_pkg::OP_EMIT_TRI2;
                    state_next = hmg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hmg_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/hemisphere_mesh_generator.sv @@
// Top level of the hemisphere mesh generator: APB register, controller and
// datapath. Depends on hmg_pkg, hmg_in_if, hmg_out_if, hmg_ctrl, hmg_datapath.
//
//  channel  | direction | transaction carries
//  ---------+-----------+-----------------------------------------------
//  in_ch    | sink      | start_req: restart at the pole or advance
//  out_ch   | source    | kind, pos_x/y/z, tex_u/v, corner_a/b/c, last
//  APB      | slave     | divisions at byte address 0
//
// A tick is taken only while the controller is idle. Start and finished
// ticks emit one result each; a row start runs the bit-serial divider
// once, for theta, and an ordinary vertex runs it once for theta and once
// for phi, then emits the vertex and one or two triangles.
// A full result register sits on out_ch; any emit waits while it is held.
// rst_n clears the mesh to the finished phase with divisions at 8.
module hemisphere_mesh_generator #(
    parameter int MAX_DIVISIONS = 127,
    parameter int ANGLE_BITS    = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    hmg_in_if.sink      in_ch,
    hmg_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0]       divisions_reg;
    hmg_pkg::cmd_t    cmd;
    hmg_pkg::status_t stat;

    assign pready = 1'b1;

    // Register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            divisions_reg <= hmg_pkg::DIVISIONS_RESET;
        else if (psel && penable && pwrite && (paddr[2] == hmg_pkg::REG_DIVISIONS))
            divisions_reg <= pwdata[6:0];
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            hmg_pkg::REG_DIVISIONS: prdata = {25'b0, divisions_reg};
            default:                prdata = '0;
        endcase
    end

    hmg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .stat  (stat),
        .cmd   (cmd)
    );

    hmg_datapath #(
        .MAX_DIVISIONS (MAX_DIVISIONS),
        .ANGLE_BITS    (ANGLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .divisions (divisions_reg),
        .cmd       (cmd),
        .stat      (stat),
        .out_ch    (out_ch)
    );

endmodule
